FILE: hdl/lphs_pkg.sv
package lphs_pkg;

    localparam int KEY_W  = 32;
    localparam int SIZE_W = 5;
    localparam int SLOT_W = 4;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd11;

    typedef enum logic [1:0] {
        OC_FOUND    = 2'd0,
        OC_INSERTED = 2'd1,
        OC_FULL     = 2'd2
    } t_outcome;

endpackage

FILE: hdl/lphs_mod.sv
// Restoring remainder unit: one dividend bit per cycle, MSB first.
module lphs_mod #(
    parameter int RW = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lphs_pkg::KEY_W-1:0]  i_dividend,
    input  logic [RW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [RW-1:0]               o_rem
);

    localparam int CNT_W = $clog2(lphs_pkg::KEY_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [lphs_pkg::KEY_W-1:0]  r_div;
    logic [RW-1:0]               r_rem;
    logic [RW-1:0]               n_trial;
    logic [RW-1:0]               n_rem;

    // remainder stays below the divisor, so the shifted value fits RW bits
    always_comb begin
        n_trial = {r_rem[RW-2:0], r_div[lphs_pkg::KEY_W-1]};
        n_rem   = (n_trial >= i_divisor) ? (n_trial - i_divisor) : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lphs_pkg::KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= r_div << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/lphs_ram.sv
// Single-port slot memory, registered read.
module lphs_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_addr,
    input  logic [lphs_pkg::KEY_W-1:0]  i_wdata,
    output logic [lphs_pkg::KEY_W-1:0]  o_rdata
);

    logic [lphs_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [lphs_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/linear_probe_hash_search_insert.sv
// Hash table, open addressing with linear probing: each key is looked up and
// inserted if absent. Home slot = key mod table size; a stored 0 marks empty.
// Input: pulse start with i_key while busy is low; the item is taken then.
// Output: o_valid is high for one cycle with o_outcome (found, inserted,
// full), o_slot and o_compare_count. The receiver has no way to stall, so
// results are only ever a single-cycle strobe.
// Config: i_cfg_we writes i_cfg_wdata to the table size; write only when idle.
// The home slot comes from a bit-serial remainder unit. Each probe then
// takes a read state and a compare state on the one memory port (read,
// compare and possibly write), with from 1 up to the effective table size
// probes; key 0 skips probing. busy drops with the strobe, and a new key
// may start in that same cycle.
// Reset: the table size goes to 11 and a clearing pass writes zero to every
// slot with busy high; config writes are still taken.
module linear_probe_hash_search_insert #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lphs_pkg::KEY_W-1:0]          i_key,
    input  logic                                i_cfg_we,
    input  logic [lphs_pkg::SIZE_W-1:0]         i_cfg_wdata,
    output logic                                o_valid,
    output logic [1:0]                          o_outcome,
    output logic [lphs_pkg::SLOT_W-1:0]         o_slot,
    output logic [lphs_pkg::SIZE_W-1:0]         o_compare_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ((AW > lphs_pkg::SIZE_W) ? AW : lphs_pkg::SIZE_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_CMP   = 5'b10000
    } t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_clr;
    logic [lphs_pkg::SIZE_W-1:0]   r_table_size;
    logic [lphs_pkg::KEY_W-1:0]    r_key;
    logic [AW-1:0]                 r_idx;
    logic [AW-1:0]                 r_home;
    logic [lphs_pkg::SIZE_W-1:0]   r_cnt;
    logic                          r_first;
    logic                          r_valid;
    lphs_pkg::t_outcome            r_outcome;
    logic [lphs_pkg::SLOT_W-1:0]   r_slot;
    logic [lphs_pkg::SIZE_W-1:0]   r_ccount;

    logic                          accept;
    logic [CW-1:0]                 size_ext;
    logic [CW-1:0]                 m_eff;
    logic                          mod_done;
    logic [CW-1:0]                 mod_rem;
    logic [AW-1:0]                 home;
    logic                          mem_we;
    logic [AW-1:0]                 mem_addr;
    logic [lphs_pkg::KEY_W-1:0]    mem_wdata;
    logic [lphs_pkg::KEY_W-1:0]    mem_rdata;
    logic                          hit;
    logic                          empty;
    logic [lphs_pkg::SIZE_W-1:0]   cnt_occ;
    logic [CW-1:0]                 idx_inc;
    logic [AW-1:0]                 next_idx;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // size 0 acts as 1, above the depth saturates
    always_comb begin
        size_ext = CW'(r_table_size);
        if (r_table_size == '0) begin
            m_eff = CW'(1);
        end else if (size_ext > DEPTH_C) begin
            m_eff = DEPTH_C;
        end else begin
            m_eff = size_ext;
        end
    end

    lphs_mod #(
        .RW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_key),
        .i_divisor  (m_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign home = mod_rem[AW-1:0];

    always_comb begin
        hit      = (mem_rdata == r_key);
        empty    = (mem_rdata == '0);
        cnt_occ  = r_first ? r_cnt : (r_cnt + 1'b1);
        idx_inc  = CW'(r_idx) + CW'(1);
        next_idx = (idx_inc == m_eff) ? '0 : idx_inc[AW-1:0];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx;
        mem_wdata = r_key;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
            end
            S_CMP: begin
                mem_we = empty && !hit;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    lphs_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= lphs_pkg::TABLE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (mod_done) begin
                        if (r_key == '0) begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (hit || empty || (next_idx == r_home)) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key;
        end
        case (r_state)
            S_HASH: begin
                r_idx     <= home;
                r_home    <= home;
                r_cnt     <= lphs_pkg::SIZE_W'(1);
                r_first   <= 1'b1;
                r_outcome <= lphs_pkg::OC_FOUND;
                r_slot    <= lphs_pkg::SLOT_W'(CW'(home));
                r_ccount  <= lphs_pkg::SIZE_W'(1);
            end
            S_CMP: begin
                if (hit) begin
                    r_outcome <= lphs_pkg::OC_FOUND;
                    r_slot    <= lphs_pkg::SLOT_W'(CW'(r_idx));
                    r_ccount  <= cnt_occ;
                end else if (empty) begin
                    r_outcome <= lphs_pkg::OC_INSERTED;
                    r_slot    <= lphs_pkg::SLOT_W'(CW'(r_idx));
                    r_ccount  <= r_cnt;
                end else begin
                    // slot holds another key: step on; table full if the next slot is home
                    r_outcome <= lphs_pkg::OC_FULL;
                    r_slot    <= lphs_pkg::SLOT_W'(CW'(r_home));
                    r_ccount  <= cnt_occ;
                    r_cnt     <= cnt_occ;
                    r_idx     <= next_idx;
                    r_first   <= 1'b0;
                end
            end
            default: begin
                r_first <= r_first;
            end
        endcase
    end

    assign o_valid         = r_valid;
    assign o_outcome       = r_outcome;
    assign o_slot          = r_slot;
    assign o_compare_count = r_ccount;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_compare_count != '0))
        else $error("result with zero compares");

    a_no_zero_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == S_CMP)) |-> (r_key != '0))
        else $error("empty marker written as a key");

endmodule

FILE: bench/tb_linear_probe_hash_search_insert.sv
module tb_linear_probe_hash_search_insert;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 1000;
    localparam int DRAIN_TAIL = 80;

    typedef struct {
        logic [lphs_pkg::KEY_W-1:0]  key;
        lphs_pkg::t_outcome          outcome;
        logic [lphs_pkg::SLOT_W-1:0] slot;
        logic [lphs_pkg::SIZE_W-1:0] count;
    } t_lookup_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [lphs_pkg::KEY_W-1:0]    i_key = '0;
    logic                          i_cfg_we = 1'b0;
    logic [lphs_pkg::SIZE_W-1:0]   i_cfg_wdata = '0;
    logic                          o_valid;
    logic [1:0]                    o_outcome;
    logic [lphs_pkg::SLOT_W-1:0]   o_slot;
    logic [lphs_pkg::SIZE_W-1:0]   o_compare_count;

    // table shadow and size register as the block should hold them
    logic [lphs_pkg::KEY_W-1:0]    slot_words [DEPTH];
    logic [lphs_pkg::SIZE_W-1:0]   table_size_q = lphs_pkg::TABLE_SIZE_RST;
    t_lookup_result                pending_lookups [$];
    int                            mismatch_count = 0;
    int                            idle_cycles = 0;

    linear_probe_hash_search_insert #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_key           (i_key),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_outcome       (o_outcome),
        .o_slot          (o_slot),
        .o_compare_count (o_compare_count)
    );

    always #5 i_clk = ~i_clk;

    // search the shadow table for one key, insert it if absent
    function automatic t_lookup_result probe_table(input logic [lphs_pkg::KEY_W-1:0] key);
        t_lookup_result r;
        int unsigned    m;
        int unsigned    home;
        int unsigned    idx;
        bit             done;
        if (table_size_q == 0)
            m = 1;
        else if (table_size_q > DEPTH)
            m = DEPTH;
        else
            m = table_size_q;
        home      = key % m;
        r.key     = key;
        r.outcome = lphs_pkg::OC_FOUND;
        r.slot    = home[lphs_pkg::SLOT_W-1:0];
        r.count   = lphs_pkg::SIZE_W'(1);
        if (key != 0 && slot_words[home] != key) begin
            if (slot_words[home] == 0) begin
                slot_words[home] = key;
                r.outcome = lphs_pkg::OC_INSERTED;
            end else begin
                // full unless the walk meets the key or a hole
                r.outcome = lphs_pkg::OC_FULL;
                idx  = (home + 1) % m;
                done = 1'b0;
                while (idx != home && !done) begin
                    if (slot_words[idx] == 0) begin
                        slot_words[idx] = key;
                        r.outcome = lphs_pkg::OC_INSERTED;
                        r.slot    = idx[lphs_pkg::SLOT_W-1:0];
                        done      = 1'b1;
                    end else begin
                        r.count++;
                        if (slot_words[idx] == key) begin
                            r.outcome = lphs_pkg::OC_FOUND;
                            r.slot    = idx[lphs_pkg::SLOT_W-1:0];
                            done      = 1'b1;
                        end else begin
                            idx = (idx + 1) % m;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // start stays high on return; the caller lowers it or sends again
    task automatic send_key(input logic [lphs_pkg::KEY_W-1:0] key);
        start <= 1'b1;
        i_key <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_lookups.push_back(probe_table(key));
    endtask

    task automatic sender_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [lphs_pkg::SIZE_W-1:0] value);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        table_size_q = value;
    endtask

    function automatic logic [lphs_pkg::KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 35)
            return slot_words[$urandom_range(DEPTH-1, 0)];
        else if (r < 65)
            return $urandom;
        else if (r < 85)
            return $urandom_range(64, 1);
        else if (r < 92)
            return '0;
        else
            return 32'hFFFF_FFFF - $urandom_range(15, 0);
    endfunction

    // one traffic phase; halfway through, the sender waits for every result
    task automatic run_phase(input logic [lphs_pkg::SIZE_W-1:0] size, input int items,
                             input int idle_pct);
        write_table_size(size);
        for (int i = 0; i < items; i++) begin
            if (i == items / 2)
                wait_drain();
            if ($urandom_range(99, 0) < idle_pct)
                sender_gap($urandom_range(80, 1));
            send_key(pick_key());
        end
    endtask

    task automatic test_key_extremes();
        send_key('0);
        send_key(32'hFFFF_FFFF);
        send_key(32'hFFFF_FFFF);
        send_key(32'd11);
        send_key(32'd22);
        send_key(32'd22);
        send_key(32'h8000_0000);
    endtask

    task automatic test_size_one();
        write_table_size(5'd1);
        send_key('0);
        send_key(32'd5);
        send_key(slot_words[0]);
        send_key($urandom);
    endtask

    task automatic test_size_zero();
        write_table_size(5'd0);
        send_key(32'd7);
        send_key(slot_words[0]);
    endtask

    task automatic test_full_small();
        write_table_size(5'd2);
        send_key(32'd2);
        send_key(32'd4);
        send_key(32'd6);
    endtask

    task automatic test_size_saturate();
        write_table_size(5'd31);
        // home 15 collisions wrap round to slot 0
        send_key(32'd15);
        send_key(32'd31);
        send_key(32'd47);
        send_key(32'd16);
        send_key(32'd31);
        write_table_size(5'd17);
        send_key(32'd63);
        send_key('0);
    endtask

    task automatic test_random_traffic();
        run_phase(5'd3,  60, 0);
        run_phase(5'd7,  80, 58);
        run_phase(5'd12, 80, 33);
        run_phase(5'd16, 80, 0);
        run_phase(5'd31, 60, 58);
        run_phase(5'd5,  50, 33);
        run_phase(5'd0,  40, 0);
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch("result with no item pending");
                end else begin
                    want = pending_lookups.pop_front();
                    if (o_outcome !== want.outcome)
                        report_mismatch($sformatf("key %h outcome %0d, want %s",
                                        want.key, o_outcome, want.outcome.name()));
                    if (o_slot !== want.slot)
                        report_mismatch($sformatf("key %h slot %0d, want %0d",
                                        want.key, o_slot, want.slot));
                    if (o_compare_count !== want.count)
                        report_mismatch($sformatf("key %h compares %0d, want %0d",
                                        want.key, o_compare_count, want.count));
                end
            end else if (o_valid !== 1'b0) begin
                report_mismatch("o_valid unknown");
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++)
            slot_words[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_key_extremes();
        test_size_one();
        test_size_zero();
        test_full_small();
        test_size_saturate();
        test_random_traffic();
        wait_drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lphs_pkg.sv
hdl/lphs_mod.sv
hdl/lphs_ram.sv
hdl/linear_probe_hash_search_insert.sv
bench/tb_linear_probe_hash_search_insert.sv
